[hdl/sgmpa_pkg.sv]
// Shared types, constants and saturating helpers for the SGM path-cost
// aggregation block. No dependencies.
package sgmpa_pkg;

    localparam int DISP_DEFAULT = 64;
    localparam int COST_W       = 8;
    localparam int IDX_W        = 6;
    localparam int CFG_IDX_W    = 1;
    localparam int M_TDATA_W    = 16;

    localparam logic [COST_W-1:0] COST_MAX  = 8'd255;
    localparam logic [COST_W-1:0] P1_RESET  = 8'd10;
    localparam logic [COST_W-1:0] P2_RESET  = 8'd200;
    localparam logic [COST_W-1:0] RMIN_INIT = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMALL_PENALTY = 1'b0,
        REG_LARGE_PENALTY = 1'b1
    } cfg_reg_t;

    // Control of one item between the sequencer and the cost datapath.
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [IDX_W-1:0]  idx;
        logic              start;
        logic              first;
        logic              last;
        logic              lo_ok;
        logic              hi_ok;
        logic              wr_bank;
    } item_ctl_t;

    function automatic logic [COST_W-1:0] sat_add8(input logic [COST_W-1:0] a,
                                                   input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

    function automatic logic [COST_W-1:0] min8(input logic [COST_W-1:0] a,
                                               input logic [COST_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

[hdl/sgmpa_seq.sv]
// Disparity sequencer: counter, first-pixel mark, bank select and read
// addresses for the path-cost memory. Depends on sgmpa_pkg.
module sgmpa_seq import sgmpa_pkg::*; #(
    parameter int DISP = DISP_DEFAULT,
    parameter int AW   = $clog2(DISP)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [COST_W-1:0] cost,
    input  logic              start,
    output logic              rd_bank,
    output logic [AW-1:0]     rd_mid,
    output logic [AW-1:0]     rd_hi,
    output item_ctl_t         ctl_reg,
    output logic [AW-1:0]     wr_addr_reg
);

    logic [AW-1:0] cnt_reg, cnt_next;
    logic          first_reg, first_next;
    logic          bank_reg, bank_next;
    logic [AW-1:0] d;
    logic [AW:0]   d_inc;
    logic          first;
    logic          last;

    always_comb begin
        d        = start ? '0 : cnt_reg;
        d_inc    = {1'b0, d} + {{AW{1'b0}}, 1'b1};
        first    = start | first_reg;
        last     = ({1'b0, d} == (AW+1)'(DISP - 1));
        rd_bank  = bank_reg;
        rd_mid   = d;
        rd_hi    = last ? d : d_inc[AW-1:0];
        cnt_next   = cnt_reg;
        first_next = first_reg;
        bank_next  = bank_reg;
        if (accept) begin
            cnt_next   = last ? '0 : d_inc[AW-1:0];
            first_next = last ? 1'b0 : first;
            bank_next  = last ? ~bank_reg : bank_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            first_reg <= 1'b0;
            bank_reg  <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            bank_reg  <= bank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctl_reg.cost    <= cost;
            ctl_reg.idx     <= IDX_W'(d);
            ctl_reg.start   <= start;
            ctl_reg.first   <= first;
            ctl_reg.last    <= last;
            ctl_reg.lo_ok   <= (d != '0);
            ctl_reg.hi_ok   <= ~last;
            ctl_reg.wr_bank <= ~bank_reg;
            wr_addr_reg     <= d;
        end
    end

endmodule

[hdl/sgmpa_vec_mem.sv]
// Two-bank path-cost vector memory: one write port, two registered read
// ports with write-to-read bypass. Depends on sgmpa_pkg.
module sgmpa_vec_mem import sgmpa_pkg::*; #(
    parameter int DISP = DISP_DEFAULT,
    parameter int AW   = $clog2(DISP)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic              rd_bank,
    input  logic [AW-1:0]     rd_mid,
    input  logic [AW-1:0]     rd_hi,
    input  logic              wr_en,
    input  logic              wr_bank,
    input  logic [AW-1:0]     wr_addr,
    input  logic [COST_W-1:0] wr_data,
    output logic [COST_W-1:0] mid_reg,
    output logic [COST_W-1:0] hi_reg
);

    logic [COST_W-1:0] mem [2][DISP];
    logic              hit_mid;
    logic              hit_hi;

    assign hit_mid = wr_en && (wr_bank == rd_bank) && (wr_addr == rd_mid);
    assign hit_hi  = wr_en && (wr_bank == rd_bank) && (wr_addr == rd_hi);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_bank][wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mid_reg <= hit_mid ? wr_data : mem[rd_bank][rd_mid];
            hi_reg  <= hit_hi  ? wr_data : mem[rd_bank][rd_hi];
        end
    end

endmodule

[hdl/sgmpa_calc.sv]
// Path-cost datapath: penalty minimum, saturation, running minimum and
// output register. Depends on sgmpa_pkg.
module sgmpa_calc import sgmpa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  item_ctl_t            ctl,
    input  logic [COST_W-1:0]    mid,
    input  logic [COST_W-1:0]    hi_rd,
    input  logic [COST_W-1:0]    p1,
    input  logic [COST_W-1:0]    p2,
    output logic                 stage_free,
    output logic                 wr_en,
    output logic [COST_W-1:0]    wr_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic              s1_valid_reg, s1_valid_next;
    logic              m_valid_reg, m_valid_next;
    logic [COST_W-1:0] run_min_reg, run_min_next;
    logic [COST_W-1:0] prev_min_reg, prev_min_next;
    logic [COST_W-1:0] lo_reg;
    logic              advance;
    logic [COST_W-1:0] lo, hi, m, diff, result, run_base, run_new;

    always_comb begin
        advance    = s1_valid_reg && (!m_valid_reg || m_tready);
        stage_free = !s1_valid_reg || advance;
        lo   = ctl.lo_ok ? lo_reg : COST_MAX;
        hi   = ctl.hi_ok ? hi_rd : COST_MAX;
        m    = min8(min8(mid, sat_add8(lo, p1)),
                    min8(sat_add8(hi, p1), sat_add8(prev_min_reg, p2)));
        diff = m - prev_min_reg;
        result   = ctl.first ? ctl.cost : sat_add8(ctl.cost, diff);
        run_base = ctl.start ? RMIN_INIT : run_min_reg;
        run_new  = min8(run_base, result);
        wr_en    = advance;
        wr_data  = result;

        s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        m_valid_next  = advance ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
        run_min_next  = run_min_reg;
        prev_min_next = prev_min_reg;
        if (advance) begin
            run_min_next  = ctl.last ? RMIN_INIT : run_new;
            prev_min_next = ctl.last ? run_new : prev_min_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            run_min_reg  <= RMIN_INIT;
            prev_min_reg <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            run_min_reg  <= run_min_next;
            prev_min_reg <= prev_min_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lo_reg  <= mid;
            m_tdata <= {(M_TDATA_W-IDX_W-COST_W)'(0), ctl.idx, result};
            m_tlast <= ctl.last;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

[hdl/sgm_path_cost_aggregation.sv]
// Top level of the SGM path-cost aggregation block: configuration
// registers and the sequencer, vector memory and datapath.
// Depends on sgmpa_pkg, sgmpa_seq, sgmpa_vec_mem, sgmpa_calc.
//
// Usage: send one matching cost per request on the s_ channel, in
// disparity order 0..DISPARITIES-1, pixel after pixel along one path;
// s_tuser marks the disparity-0 request of a path's first pixel.
// Each request gives one result on the m_ channel: the aggregated path
// cost, its disparity index and m_tlast on the last disparity of a pixel.
// Requests and results are both registered. One request is taken per
// cycle unless the receiver stalls, set by the single read-modify-write
// pass through the two-bank vector memory (one bank holds the previous
// pixel, the other collects the current one; banks swap at the end of
// each pixel). When the receiver stalls, the output register and the
// datapath stage hold and s_tready drops once both are full; nothing is
// lost. Reset clears the counter, the minima and the penalties to 10 and
// 200; the memory is not cleared, so a path must open with s_tuser set.
// Write penalties on the cfg_ channel only while the block is idle.
module sgm_path_cost_aggregation import sgmpa_pkg::*; #(
    parameter int DISPARITIES = DISP_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] match_cost
    input  logic                 s_tuser,   // [0] path_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] path_cost, [13:8] disparity_index
    output logic                 m_tlast,   // pixel_done
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COST_W-1:0]    cfg_data
);

    localparam int AW = $clog2(DISPARITIES);

    logic [COST_W-1:0] p1_reg, p1_next;
    logic [COST_W-1:0] p2_reg, p2_next;
    logic              accept;
    logic              stage_free;
    logic              rd_bank;
    logic [AW-1:0]     rd_mid, rd_hi, wr_addr;
    item_ctl_t         ctl;
    logic [COST_W-1:0] mid, hi_rd, wr_data;
    logic              wr_en;

    assign cfg_ready = 1'b1;
    assign s_tready  = stage_free;
    assign accept    = s_tvalid && stage_free;

    always_comb begin
        p1_next = p1_reg;
        p2_next = p2_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SMALL_PENALTY: p1_next = cfg_data;
                REG_LARGE_PENALTY: p2_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg <= P1_RESET;
            p2_reg <= P2_RESET;
        end else begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    sgmpa_seq #(.DISP(DISPARITIES), .AW(AW)) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .cost        (s_tdata),
        .start       (s_tuser),
        .rd_bank     (rd_bank),
        .rd_mid      (rd_mid),
        .rd_hi       (rd_hi),
        .ctl_reg     (ctl),
        .wr_addr_reg (wr_addr)
    );

    sgmpa_vec_mem #(.DISP(DISPARITIES), .AW(AW)) u_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_bank (rd_bank),
        .rd_mid  (rd_mid),
        .rd_hi   (rd_hi),
        .wr_en   (wr_en),
        .wr_bank (ctl.wr_bank),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .mid_reg (mid),
        .hi_reg  (hi_rd)
    );

    sgmpa_calc u_calc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .ctl        (ctl),
        .mid        (mid),
        .hi_rd      (hi_rd),
        .p1         (p1_reg),
        .p2         (p2_reg),
        .stage_free (stage_free),
        .wr_en      (wr_en),
        .wr_data    (wr_data),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[tb/tb_sgm_path_cost_aggregation.sv]
// Testbench for sgm_path_cost_aggregation: streams matching costs along aggregation paths
// with random gaps and stalls, predicts every aggregated path cost and checks each result.
// Depends on sgmpa_pkg and the block's RTL.
module tb_sgm_path_cost_aggregation;
    timeunit 1ns;
    timeprecision 1ps;

    import sgmpa_pkg::*;

    localparam int DISP = DISP_DEFAULT;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [IDX_W-1:0]  disp;
        logic              done;
    } agg_result_t;

    typedef enum int {
        FLAT_NOISE,
        RAILS,
        DRIFT,
        NEAR_ZERO,
        VALLEY
    } cost_shape_t;

    class path_cost_scoreboard;
        logic [COST_W-1:0] p1;
        logic [COST_W-1:0] p2;
        logic [COST_W-1:0] prev_min;
        logic [COST_W-1:0] run_min;
        logic [COST_W-1:0] prev_path [DISP];
        logic [COST_W-1:0] cur_path [DISP];
        int unsigned       disp;
        bit                opening_pixel;
        agg_result_t       awaited_costs [$];
        int unsigned       mismatches;
        int unsigned       results_seen;

        function new();
            p1 = P1_RESET;
            p2 = P2_RESET;
            prev_min = '0;
            run_min = RMIN_INIT;
            disp = 0;
            opening_pixel = 1'b0;
            mismatches = 0;
            results_seen = 0;
            foreach (prev_path[i]) begin
                prev_path[i] = '0;
                cur_path[i] = '0;
            end
        endfunction

        function logic [COST_W-1:0] clip_sum(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
            logic [COST_W:0] total;
            total = {1'b0, a} + {1'b0, b};
            return (total > COST_MAX) ? COST_MAX : total[COST_W-1:0];
        endfunction

        function void write_penalty(logic [CFG_IDX_W-1:0] index, logic [COST_W-1:0] value);
            if (index == REG_SMALL_PENALTY)
                p1 = value;
            else if (index == REG_LARGE_PENALTY)
                p2 = value;
        endfunction

        function void note_request(logic [COST_W-1:0] cost, logic start);
            logic [COST_W-1:0] below;
            logic [COST_W-1:0] above;
            logic [COST_W-1:0] best;
            logic [COST_W-1:0] result;
            agg_result_t       expected;
            if (start) begin
                disp = 0;
                opening_pixel = 1'b1;
                run_min = RMIN_INIT;
            end
            if (disp >= DISP)
                disp = 0;
            if (opening_pixel) begin
                result = cost;
            end else begin
                below = (disp > 0) ? prev_path[disp-1] : COST_MAX;
                above = (disp + 1 < DISP) ? prev_path[disp+1] : COST_MAX;
                best = prev_path[disp];
                if (clip_sum(below, p1) < best)
                    best = clip_sum(below, p1);
                if (clip_sum(above, p1) < best)
                    best = clip_sum(above, p1);
                if (clip_sum(prev_min, p2) < best)
                    best = clip_sum(prev_min, p2);
                result = clip_sum(cost, best - prev_min);
            end
            cur_path[disp] = result;
            if (result < run_min)
                run_min = result;
            expected.cost = result;
            expected.disp = IDX_W'(disp);
            expected.done = (disp == DISP - 1);
            awaited_costs.push_back(expected);
            if (expected.done) begin
                prev_path = cur_path;
                prev_min = run_min;
                run_min = RMIN_INIT;
                disp = 0;
                opening_pixel = 1'b0;
            end else begin
                disp++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tlast);
            agg_result_t want;
            results_seen++;
            if (awaited_costs.size() == 0) begin
                $display("%0t: result with nothing awaited: tdata %h tlast %b",
                         $time, tdata, tlast);
                mismatches++;
                return;
            end
            want = awaited_costs.pop_front();
            if (tdata[COST_W-1:0] !== want.cost) begin
                $display("%0t: path_cost expected %0d actual %0d",
                         $time, want.cost, tdata[COST_W-1:0]);
                mismatches++;
            end
            if (tdata[COST_W+IDX_W-1:COST_W] !== want.disp) begin
                $display("%0t: disparity_index expected %0d actual %0d",
                         $time, want.disp, tdata[COST_W+IDX_W-1:COST_W]);
                mismatches++;
            end
            if (tlast !== want.done) begin
                $display("%0t: pixel_done expected %b actual %b", $time, want.done, tlast);
                mismatches++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COST_W-1:0]    cfg_data = '0;

    path_cost_scoreboard sb = new();

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          stim_disp = 0;
    int unsigned requests_sent = 0;
    int unsigned paths_opened = 0;
    int unsigned restarts = 0;
    int unsigned settings_tried = 0;

    sgm_path_cost_aggregation #(
        .DISPARITIES(DISP)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_penalty(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_cost(input logic [COST_W-1:0] cost, input logic start);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cost;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        if (start) begin
            if (stim_disp == 0)
                paths_opened++;
            else
                restarts++;
            stim_disp = 1;
        end else begin
            stim_disp = (stim_disp + 1) % DISP;
        end
    endtask

    task automatic write_reg(input cfg_reg_t index, input logic [COST_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_phase(input logic [COST_W-1:0] small_p, input logic [COST_W-1:0] large_p,
                             input int idle, input int stall);
        write_reg(REG_SMALL_PENALTY, small_p);
        write_reg(REG_LARGE_PENALTY, large_p);
        cfg_valid <= 1'b0;
        settings_tried++;
        idle_pct = idle;
        stall_pct = stall;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.awaited_costs.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_random(input int count);
        cost_shape_t       shape;
        int                level;
        int                center;
        int                item_disp;
        int                gap;
        logic [COST_W-1:0] cost;
        logic              start;
        shape = FLAT_NOISE;
        level = 128;
        center = 0;
        for (int n = 0; n < count; n++) begin
            start = 1'b0;
            if (stim_disp == 0) begin
                shape = cost_shape_t'($urandom_range(0, 4));
                level = $urandom_range(0, 255);
                center = $urandom_range(0, DISP - 1);
                start = ($urandom_range(0, 99) < 15);
            end else if ($urandom_range(0, 149) == 0) begin
                start = 1'b1;
            end
            item_disp = start ? 0 : stim_disp;
            case (shape)
                FLAT_NOISE: cost = COST_W'($urandom_range(0, 255));
                RAILS:      cost = $urandom_range(0, 1) ? COST_MAX : '0;
                DRIFT: begin
                    level = level + int'($urandom_range(0, 8)) - 4;
                    if (level < 0)
                        level = 0;
                    if (level > 255)
                        level = 255;
                    cost = COST_W'(level);
                end
                NEAR_ZERO:  cost = COST_W'($urandom_range(0, 20));
                default: begin
                    gap = (item_disp > center) ? item_disp - center : center - item_disp;
                    if (gap < 4)
                        cost = COST_W'(gap * 20);
                    else
                        cost = COST_W'(255 - $urandom_range(0, 40));
                end
            endcase
            send_cost(cost, start);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_cost(8'd0, 1'b1);
        send_cost(8'd255, 1'b0);
        send_cost(8'd0, 1'b0);
        send_cost(8'd255, 1'b0);
        send_cost(8'd128, 1'b0);
        send_cost(8'd1, 1'b0);
        send_cost(8'd254, 1'b0);
        send_cost(8'd127, 1'b0);
        send_cost(8'd255, 1'b1);
        send_cost(8'd255, 1'b0);
        send_cost(8'd0, 1'b0);
        send_cost(8'd17, 1'b0);
        send_cost(8'd200, 1'b0);
        send_cost(8'd3, 1'b0);
        send_cost(8'd85, 1'b0);
        send_cost(8'd170, 1'b0);
        send_cost(8'd0, 1'b1);
        send_cost(8'd255, 1'b0);
        run_random(200);
        drain();

        set_phase(8'd0, 8'd0, 75, 0);
        run_random(225);
        drain();
        set_phase(8'd255, 8'd255, 0, 75);
        run_random(225);
        drain();
        set_phase(8'd0, 8'd255, 13, 13);
        run_random(225);
        drain();
        set_phase(8'd255, 8'd0, 0, 0);
        run_random(225);
        drain();
        set_phase(COST_W'($urandom_range(1, 60)), COST_W'($urandom_range(20, 255)), 75, 75);
        run_random(225);
        drain();

        $display("run covered %0d requests and %0d results, %0d path starts,",
                 requests_sent, sb.results_seen, paths_opened);
        $display("%0d restarts mid-pixel, %0d penalty pairs written, zero and full scale among them",
                 restarts, settings_tried);
        if (sb.mismatches == 0) begin
            $display("tb_sgm_path_cost_aggregation: clean");
        end else begin
            $display("tb_sgm_path_cost_aggregation: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results still awaited", sb.awaited_costs.size());
        $display("tb_sgm_path_cost_aggregation: errors");
        $finish;
    end

endmodule

[sim.f]
hdl/sgmpa_pkg.sv
hdl/sgmpa_seq.sv
hdl/sgmpa_vec_mem.sv
hdl/sgmpa_calc.sv
hdl/sgm_path_cost_aggregation.sv
tb/tb_sgm_path_cost_aggregation.sv
